// ----- design/dhfwm_pkg.sv -----
`timescale 1ns / 1ps

package dhfwm_pkg;

    // Fixed field widths of the stream words
    localparam int DEPTH_BITS = 16;
    localparam int ROW_W      = 12;
    localparam int OUT_COL_W  = 10;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 4;

    // Frame height limit and the register holding it
    localparam int HEIGHT_LIMIT = 4096;
    localparam int HEIGHT_W     = 13;

    // Configuration port
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_RADIUS_W = 3;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    localparam int RESET_RADIUS = 1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_WINDOW_RADIUS = 2'd2
    } cfg_reg_t;

    // Input word kind carried on s_tuser
    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } cmd_t;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;
    localparam int OUT_PAD_W = M_TDATA_W - DEPTH_BITS - ROW_W - OUT_COL_W;

    // Output queue
    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic                  last;
        logic [OUT_COL_W-1:0]  col;
        logic [ROW_W-1:0]      row;
        logic [DEPTH_BITS-1:0] depth;
    } out_item_t;

endpackage

// ----- design/depth_hole_fill_window_max_core.sv -----
`timescale 1ns / 1ps
// A result word released by an input word passes through the s1 and s2 registers and the output queue to m_tvalid.
// Throughput: one word per cycle, sustained; a 4-entry output queue with credit from the
//   in-flight count keeps s_tready high while m_tready is high.
// Pixels are delayed R rows plus R pixels through a ring of 2*MAX_RADIUS+1 line banks.
// Reset: aresetn is synchronous, active low; it clears positions, counts, valids and the
//   queue, and loads the default geometry. Line banks are not cleared.
module depth_hole_fill_window_max_core #(
    parameter int MAX_WIDTH  = dhfwm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = dhfwm_pkg::DEF_MAX_RADIUS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port
    input  logic                             cfg_we,
    input  logic [dhfwm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [dhfwm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dhfwm_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] depth_in
    input  logic                             s_tuser,   // [0] cmd
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [dhfwm_pkg::M_TDATA_W-1:0]  m_tdata,   // [15:0] depth_out, [27:16] out_row,
                                                        // [37:28] out_col, [39:38] zero
    output logic                             m_tlast    // frame_last
);
    import dhfwm_pkg::*;

    localparam int RING  = 2 * MAX_RADIUS + 1;
    localparam int SW    = $clog2(RING);
    localparam int TW    = SW + 2;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int XW    = CW + 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int LW    = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);
    localparam int FP_W  = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int RST_WIDTH  = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
    localparam int RST_RADIUS = (RESET_RADIUS > MAX_RADIUS) ? MAX_RADIUS : RESET_RADIUS;

    typedef struct packed {
        logic                  valid;
        logic                  interior;
        logic                  last;
        logic [CW-1:0]         x;
        logic [ROW_W-1:0]      y;
        logic [SW-1:0]         top;
        logic [SW-1:0]         cslot;
        logic                  wr_hit;
        logic [SW-1:0]         wr_bank;
        logic                  hit_a;
        logic                  hit_b;
        logic [DEPTH_BITS-1:0] wr_data;
    } s1_t;

    typedef struct packed {
        logic                  valid;
        logic                  interior;
        logic                  last;
        logic [CW-1:0]         x;
        logic [ROW_W-1:0]      y;
        logic [DEPTH_BITS-1:0] center;
    } s2_t;

    function automatic logic [WW-1:0] clamp_width(input logic [CFG_WIDTH_W-1:0] raw);
        if (raw == '0) begin
            return WW'(1);
        end else if (int'(raw) > MAX_WIDTH) begin
            return WW'(MAX_WIDTH);
        end
        return WW'(raw);
    endfunction

    function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [CFG_HEIGHT_W-1:0] raw);
        if (raw == '0) begin
            return HEIGHT_W'(1);
        end else if (int'(raw) > HEIGHT_LIMIT) begin
            return HEIGHT_W'(HEIGHT_LIMIT);
        end
        return HEIGHT_W'(raw);
    endfunction

    function automatic logic [RW-1:0] clamp_radius(input logic [CFG_RADIUS_W-1:0] raw);
        if (int'(raw) > MAX_RADIUS) begin
            return RW'(MAX_RADIUS);
        end
        return RW'(raw);
    endfunction

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] slot);
        if (slot == SW'(RING - 1)) begin
            return '0;
        end
        return slot + SW'(1);
    endfunction

    // Geometry and stream position
    logic [WW-1:0]       eff_width_reg,  eff_width_next;
    logic [HEIGHT_W-1:0] eff_height_reg, eff_height_next;
    logic [RW-1:0]       eff_radius_reg, eff_radius_next;
    logic [CW-1:0]       in_col_reg,     in_col_next;
    logic [ROW_W-1:0]    in_row_reg,     in_row_next;
    logic [SW-1:0]       in_slot_reg,    in_slot_next;
    logic [CW-1:0]       out_x_reg,      out_x_next;
    logic [ROW_W-1:0]    out_y_reg,      out_y_next;
    logic [SW-1:0]       out_slot_reg,   out_slot_next;
    logic [LW-1:0]       pending_reg,    pending_next;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;

    logic [DEPTH_BITS-1:0] rd_a [RING];
    logic [DEPTH_BITS-1:0] rd_b [RING];
    logic [DEPTH_BITS-1:0] col_chain_reg [RING];

    out_item_t          fifo_mem [FIFO_DEPTH];
    logic [FP_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [FP_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;

    logic                  accept;
    logic                  is_flush;
    logic                  pix_acc;
    logic                  emit;
    logic [LW-1:0]         lag;
    logic [LW-1:0]         pending_inc;
    logic [XW-1:0]         x_plus_r;
    logic                  x_fits;
    logic                  y_fits;
    logic [CW-1:0]         push_col;
    logic [TW-1:0]         top_sum;
    logic [TW-1:0]         two_r;
    logic [DEPTH_BITS-1:0] colmax;
    logic [DEPTH_BITS-1:0] center;
    logic [DEPTH_BITS-1:0] winmax;
    logic [DEPTH_BITS-1:0] a_val;
    logic [TW-1:0]         rel;
    out_item_t             push_item;
    out_item_t             head_item;
    logic                  fifo_push;
    logic                  fifo_pop;

    // Credit: take a word only if the queue can hold everything in flight
    assign s_tready = (int'(count_reg) + int'(s1_reg.valid) + int'(s2_reg.valid)) < FIFO_DEPTH;

    assign accept   = s_tvalid && s_tready;
    assign is_flush = (s_tuser == CMD_FLUSH);
    assign pix_acc  = accept && !is_flush;
    assign two_r    = TW'(eff_radius_reg) << 1;

    // Emit decision, output position and stream counters
    always_comb begin
        lag         = LW'(eff_radius_reg) * LW'(eff_width_reg) + LW'(eff_radius_reg);
        pending_inc = pending_reg + LW'(1);

        if (is_flush) begin
            emit = accept && (pending_reg != '0) && (in_row_reg == '0) && (in_col_reg == '0);
        end else begin
            emit = accept && (pending_inc > lag);
        end

        // Column pushed into the window chain lies r pixels ahead of the output pixel
        x_plus_r = XW'(out_x_reg) + XW'(eff_radius_reg);
        x_fits   = x_plus_r < XW'(eff_width_reg);
        push_col = x_fits ? CW'(x_plus_r) : CW'(x_plus_r - XW'(eff_width_reg));
        y_fits   = (HEIGHT_W'(out_y_reg) + HEIGHT_W'(eff_radius_reg)) < eff_height_reg;

        // Ring slot of the top row of that column
        top_sum = TW'(out_slot_reg) + TW'(RING) - TW'(eff_radius_reg) + TW'(!x_fits);
        if (top_sum >= TW'(RING)) begin
            top_sum = top_sum - TW'(RING);
        end
        if (top_sum >= TW'(RING)) begin
            top_sum = top_sum - TW'(RING);
        end

        s1_next.valid    = emit;
        s1_next.interior = (WW'(out_x_reg) >= WW'(eff_radius_reg)) && x_fits
                           && (out_y_reg >= ROW_W'(eff_radius_reg)) && y_fits;
        s1_next.last     = (WW'(out_x_reg) == eff_width_reg - WW'(1))
                           && (HEIGHT_W'(out_y_reg) == eff_height_reg - HEIGHT_W'(1));
        s1_next.x        = out_x_reg;
        s1_next.y        = out_y_reg;
        s1_next.top      = SW'(top_sum);
        s1_next.cslot    = out_slot_reg;
        s1_next.wr_hit   = pix_acc;
        s1_next.wr_bank  = in_slot_reg;
        s1_next.hit_a    = (in_col_reg == push_col);
        s1_next.hit_b    = (in_col_reg == out_x_reg);
        s1_next.wr_data  = s_tdata[DEPTH_BITS-1:0];

        eff_width_next  = eff_width_reg;
        eff_height_next = eff_height_reg;
        eff_radius_next = eff_radius_reg;
        in_col_next     = in_col_reg;
        in_row_next     = in_row_reg;
        in_slot_next    = in_slot_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_slot_next   = out_slot_reg;
        pending_next    = pending_reg;

        // Advance the input position on a pixel
        if (pix_acc) begin
            pending_next = pending_inc;
            if ((WW'(in_col_reg) + WW'(1)) == eff_width_reg) begin
                in_col_next  = '0;
                in_slot_next = slot_inc(in_slot_reg);
                if ((HEIGHT_W'(in_row_reg) + HEIGHT_W'(1)) == eff_height_reg) begin
                    in_row_next = '0;
                end else begin
                    in_row_next = in_row_reg + ROW_W'(1);
                end
            end else begin
                in_col_next = in_col_reg + CW'(1);
            end
        end

        // Advance the output position on an emit
        if (emit) begin
            pending_next = pending_next - LW'(1);
            if ((WW'(out_x_reg) + WW'(1)) == eff_width_reg) begin
                out_x_next    = '0;
                out_slot_next = slot_inc(out_slot_reg);
                if ((HEIGHT_W'(out_y_reg) + HEIGHT_W'(1)) == eff_height_reg) begin
                    out_y_next = '0;
                end else begin
                    out_y_next = out_y_reg + ROW_W'(1);
                end
            end else begin
                out_x_next = out_x_reg + CW'(1);
            end
        end

        // Register write restarts the stream
        if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_FRAME_WIDTH:   eff_width_next  = clamp_width(cfg_wdata[CFG_WIDTH_W-1:0]);
                REG_FRAME_HEIGHT:  eff_height_next = clamp_height(cfg_wdata[CFG_HEIGHT_W-1:0]);
                REG_WINDOW_RADIUS: eff_radius_next = clamp_radius(cfg_wdata[CFG_RADIUS_W-1:0]);
                default: ;
            endcase
            if (cfg_addr == REG_FRAME_WIDTH || cfg_addr == REG_FRAME_HEIGHT
                || cfg_addr == REG_WINDOW_RADIUS) begin
                in_col_next   = '0;
                in_row_next   = '0;
                in_slot_next  = '0;
                out_x_next    = '0;
                out_y_next    = '0;
                out_slot_next = '0;
                pending_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_width_reg  <= WW'(RST_WIDTH);
            eff_height_reg <= HEIGHT_W'(RESET_HEIGHT);
            eff_radius_reg <= RW'(RST_RADIUS);
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            in_slot_reg    <= '0;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_slot_reg   <= '0;
            pending_reg    <= '0;
        end else begin
            eff_width_reg  <= eff_width_next;
            eff_height_reg <= eff_height_next;
            eff_radius_reg <= eff_radius_next;
            in_col_reg     <= in_col_next;
            in_row_reg     <= in_row_next;
            in_slot_reg    <= in_slot_next;
            out_x_reg      <= out_x_next;
            out_y_reg      <= out_y_next;
            out_slot_reg   <= out_slot_next;
            pending_reg    <= pending_next;
        end
    end

    // Line banks: one per ring row, one write and two registered reads each
    for (genvar b = 0; b < RING; b++) begin : g_bank
        logic [DEPTH_BITS-1:0] mem [MAX_WIDTH];
        logic [DEPTH_BITS-1:0] rd_a_reg;
        logic [DEPTH_BITS-1:0] rd_b_reg;

        always_ff @(posedge aclk) begin
            if (pix_acc && (in_slot_reg == SW'(b))) begin
                mem[in_col_reg] <= s_tdata[DEPTH_BITS-1:0];
            end
            rd_a_reg <= mem[push_col];
            rd_b_reg <= mem[out_x_reg];
        end

        assign rd_a[b] = rd_a_reg;
        assign rd_b[b] = rd_b_reg;
    end

    // Stage 1: column maximum over the 2r+1 window rows, center pixel
    always_comb begin
        colmax = '0;
        center = '0;
        for (int b = 0; b < RING; b++) begin
            a_val = (s1_reg.wr_hit && s1_reg.wr_bank == SW'(b) && s1_reg.hit_a)
                    ? s1_reg.wr_data : rd_a[b];
            rel = TW'(b) + TW'(RING) - TW'(s1_reg.top);
            if (rel >= TW'(RING)) begin
                rel = rel - TW'(RING);
            end
            if (rel <= two_r && a_val > colmax) begin
                colmax = a_val;
            end
            if (s1_reg.cslot == SW'(b)) begin
                center = (s1_reg.wr_hit && s1_reg.wr_bank == SW'(b) && s1_reg.hit_b)
                         ? s1_reg.wr_data : rd_b[b];
            end
        end

        s2_next.valid    = s1_reg.valid;
        s2_next.interior = s1_reg.interior;
        s2_next.last     = s1_reg.last;
        s2_next.x        = s1_reg.x;
        s2_next.y        = s1_reg.y;
        s2_next.center   = center;
    end

    // Advance the pipeline stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= '0;
            s2_reg <= '0;
        end else begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    // Shift the column maxima on every emitted pixel
    always_ff @(posedge aclk) begin
        if (s1_reg.valid) begin
            col_chain_reg[0] <= colmax;
            for (int j = 1; j < RING; j++) begin
                col_chain_reg[j] <= col_chain_reg[j-1];
            end
        end
    end

    // Stage 2: window maximum over the newest 2r+1 columns, fill a hole
    always_comb begin
        winmax = '0;
        for (int j = 0; j < RING; j++) begin
            if (TW'(j) <= two_r && col_chain_reg[j] > winmax) begin
                winmax = col_chain_reg[j];
            end
        end
        push_item.depth = (s2_reg.interior && s2_reg.center == '0) ? winmax : s2_reg.center;
        push_item.row   = s2_reg.y;
        push_item.col   = OUT_COL_W'(s2_reg.x);
        push_item.last  = s2_reg.last;
    end

    // Output queue
    assign fifo_push = s2_reg.valid;
    assign fifo_pop  = m_tvalid && m_tready;
    assign head_item = fifo_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (fifo_push) begin
            wr_ptr_next = wr_ptr_reg + FP_W'(1);
        end
        if (fifo_pop) begin
            rd_ptr_next = rd_ptr_reg + FP_W'(1);
        end
        if (fifo_push && !fifo_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!fifo_push && fifo_pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (fifo_push) begin
            fifo_mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, head_item.col, head_item.row, head_item.depth};
    assign m_tlast  = head_item.last;

`ifndef SYNTHESIS
    // Credit scheme must leave room for every word reaching the queue
    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_reg.valid |-> (count_reg < CNT_W'(FIFO_DEPTH)))
        else $error("output queue written while full");

    // Pending count never exceeds the delay line length
    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= lag)
        else $error("pending count above lag");

    // A flush with nothing pending releases no word
    a_flush_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == CMD_FLUSH && pending_reg == '0)
        |=> !s1_reg.valid)
        else $error("flush emitted with nothing pending");

    // Emitted rows stay inside the frame
    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (HEIGHT_W'(head_item.row) < eff_height_reg))
        else $error("output row beyond frame height");
`endif

endmodule
